>>> rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the block buffer cache tag store.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Default number of buffer slots
  localparam int unsigned SLOTS_DEF = 32;

  // Field widths fixed by the request format
  localparam int unsigned DEV_W   = 8;
  localparam int unsigned BLK_W   = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOSLOT = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } st_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_OP
  } state_e;

  // One slot entry as held in the tag memory
  typedef struct packed {
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
    logic               dv;
  } rec_t;

  // Scan unit control
  typedef struct packed {
    logic clr;  // start a new search
    logic vld;  // an entry is presented this cycle
  } scan_ctl_t;

  // Scan unit findings
  typedef struct packed {
    logic hit;  // tag match seen
    logic vic;  // unreferenced slot seen
  } scan_flags_t;

endpackage

>>> rtl/bbc_store.sv
// ----------------------------------------------------------------------------
// bbc_store
// Slot entry memory: one write port, one registered read port. Per-entry
// written bits make untouched entries read back as all zero after reset.
// ----------------------------------------------------------------------------
module bbc_store #(
  parameter int unsigned SLOTS = bbc_pkg::SLOTS_DEF,
  localparam int unsigned IW   = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  bbc_pkg::rec_t wdata_i,
  input  logic [IW-1:0] raddr_i,
  output bbc_pkg::rec_t rdata_o
);

  bbc_pkg::rec_t mem [SLOTS];
  logic [SLOTS-1:0] wr_q;
  bbc_pkg::rec_t rd_q;
  logic rd_wr_q;

  // Entry storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // Written marks, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_wr_q <= 1'b0;
    end else begin
      if (we_i) begin
        wr_q[waddr_i] <= 1'b1;
      end
      rd_wr_q <= wr_q[raddr_i];
    end
  end

  // Never-written entries read as reset value
  assign rdata_o = rd_wr_q ? rd_q : '0;

endmodule

>>> rtl/bbc_scan.sv
// ----------------------------------------------------------------------------
// bbc_scan
// Shared compare unit: sees one slot entry per cycle, keeps the first tag
// match and the unreferenced slot with the oldest release stamp.
// ----------------------------------------------------------------------------
module bbc_scan #(
  parameter int unsigned SLOTS = bbc_pkg::SLOTS_DEF,
  localparam int unsigned IW   = $clog2(SLOTS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bbc_pkg::scan_ctl_t               ctl_i,
  input  bbc_pkg::rec_t                    rec_i,
  input  logic [IW-1:0]                    idx_i,
  input  logic [bbc_pkg::DEV_W-1:0]        dev_i,
  input  logic [bbc_pkg::BLK_W-1:0]        blk_i,
  output bbc_pkg::scan_flags_t             flags_o,
  output logic [IW-1:0]                    hit_idx_o,
  output bbc_pkg::rec_t                    hit_rec_o,
  output logic [IW-1:0]                    vic_idx_o,
  output logic [bbc_pkg::STAMP_W-1:0]      vic_stamp_o
);

  bbc_pkg::scan_flags_t flags_q, flags_d;
  logic [IW-1:0] hit_idx_q, vic_idx_q;
  bbc_pkg::rec_t hit_rec_q;
  logic [bbc_pkg::STAMP_W-1:0] vic_stamp_q;
  logic take_hit, take_vic;

  // Compare the presented entry against the request and the best victim
  always_comb begin
    take_hit = ctl_i.vld && !flags_q.hit && (rec_i.dev == dev_i) && (rec_i.blk == blk_i);
    take_vic = ctl_i.vld && (rec_i.cnt == '0) &&
               (!flags_q.vic || (rec_i.stamp < vic_stamp_q));
    flags_d = flags_q;
    if (ctl_i.clr) begin
      flags_d = '0;
    end else begin
      if (take_hit) flags_d.hit = 1'b1;
      if (take_vic) flags_d.vic = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Captured candidates
  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q <= idx_i;
      hit_rec_q <= rec_i;
    end
    if (take_vic) begin
      vic_idx_q   <= idx_i;
      vic_stamp_q <= rec_i.stamp;
    end
  end

  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_rec_o   = hit_rec_q;
  assign vic_idx_o   = vic_idx_q;
  assign vic_stamp_o = vic_stamp_q;

endmodule

>>> rtl/block_buffer_cache_lru_unit.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit
// Tag store of a disk block buffer cache with least-recently-released
// replacement.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. A get walks all
// SLOTS entries through the single read port of the entry memory, one per
// cycle, and then passes the S_FIN state before its result strobes. Release,
// pin and unpin read their entry in the accept cycle and strobe after their S_OP
// state; one with slot_in_i beyond the slot count strobes in the cycle after it.
// busy_o drops in the strobe cycle, so the next request may be taken there.
// Each result is on the ports for exactly one cycle with done_o high; the
// receiver cannot stall, so it must take every result as it comes.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit #(
  parameter int unsigned SLOTS = bbc_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic [bbc_pkg::DEV_W-1:0]     device_i,
  input  logic [bbc_pkg::BLK_W-1:0]     block_number_i,
  input  logic [bbc_pkg::SLOT_W-1:0]    slot_in_i,
  input  logic [bbc_pkg::STAMP_W-1:0]   now_i,
  output logic                          done_o,
  output logic [bbc_pkg::SLOT_W-1:0]    slot_out_o,
  output logic                          hit_o,
  output logic                          needs_read_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned XW = IW + bbc_pkg::SLOT_W;

  bbc_pkg::state_e state_q, state_d;

  logic [IW:0]   iss_q, iss_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q;
  logic          done_q, done_d;

  bbc_pkg::op_e                  op_q;
  logic [bbc_pkg::DEV_W-1:0]     dev_q;
  logic [bbc_pkg::BLK_W-1:0]     blk_q;
  logic [bbc_pkg::SLOT_W-1:0]    slot_in_q;
  logic [IW-1:0]                 slot_q;
  logic [bbc_pkg::STAMP_W-1:0]   now_q;

  logic [bbc_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;
  logic                       res_hit_q, res_hit_d;
  logic                       res_rd_q, res_rd_d;
  bbc_pkg::st_e               res_st_q, res_st_d;

  logic          accept, is_get, out_of_range;
  logic [IW-1:0] slot_idx_in;
  logic [XW-1:0] slot_in_x, hit_idx_x, vic_idx_x;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  bbc_pkg::rec_t wrec, rrec;

  bbc_pkg::scan_ctl_t   scan_ctl;
  bbc_pkg::scan_flags_t scan_flags;
  logic [IW-1:0]        hit_idx, vic_idx;
  bbc_pkg::rec_t        hit_rec;
  logic [bbc_pkg::STAMP_W-1:0] vic_stamp;
  logic [bbc_pkg::CNT_W-1:0]   cnt_dec;

  // Request decode
  assign accept       = start_i && (state_q == bbc_pkg::S_IDLE);
  assign is_get       = (opcode_i == bbc_pkg::OP_GET);
  assign out_of_range = 32'(slot_in_i) >= 32'(SLOTS);
  assign slot_in_x    = {{IW{1'b0}}, slot_in_i};
  assign slot_idx_in  = slot_in_x[IW-1:0];
  assign hit_idx_x    = {{bbc_pkg::SLOT_W{1'b0}}, hit_idx};
  assign vic_idx_x    = {{bbc_pkg::SLOT_W{1'b0}}, vic_idx};
  assign cnt_dec      = rrec.cnt - 1'b1;

  bbc_store #(.SLOTS(SLOTS)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrec),
    .raddr_i (raddr),
    .rdata_o (rrec)
  );

  bbc_scan #(.SLOTS(SLOTS)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .rec_i       (rrec),
    .idx_i       (rd_idx_q),
    .dev_i       (dev_q),
    .blk_i       (blk_q),
    .flags_o     (scan_flags),
    .hit_idx_o   (hit_idx),
    .hit_rec_o   (hit_rec),
    .vic_idx_o   (vic_idx),
    .vic_stamp_o (vic_stamp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbc_pkg::S_IDLE: begin
        if (accept) begin
          if (is_get) begin
            state_d = bbc_pkg::S_SCAN;
          end else if (!out_of_range) begin
            state_d = bbc_pkg::S_OP;
          end
        end
      end
      bbc_pkg::S_SCAN: begin
        if ((iss_q == (IW+1)'(SLOTS)) && !rd_vld_q) begin
          state_d = bbc_pkg::S_FIN;
        end
      end
      bbc_pkg::S_FIN:  state_d = bbc_pkg::S_IDLE;
      bbc_pkg::S_OP:   state_d = bbc_pkg::S_IDLE;
      default:         state_d = bbc_pkg::S_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    done_d     = 1'b0;
    scan_ctl   = '0;
    raddr      = iss_q[IW-1:0];
    we         = 1'b0;
    waddr      = slot_q;
    wrec       = rrec;
    res_slot_d = res_slot_q;
    res_hit_d  = res_hit_q;
    res_rd_d   = res_rd_q;
    res_st_d   = res_st_q;
    unique case (state_q)
      bbc_pkg::S_IDLE: begin
        // Non-get requests read their slot in the accept cycle
        raddr = slot_idx_in;
        if (accept) begin
          iss_d        = '0;
          scan_ctl.clr = 1'b1;
          if (!is_get && out_of_range) begin
            res_slot_d = slot_in_i;
            res_hit_d  = 1'b0;
            res_rd_d   = 1'b0;
            res_st_d   = bbc_pkg::ST_NOSLOT;
            done_d     = 1'b1;
          end
        end
      end
      bbc_pkg::S_SCAN: begin
        // Issue one entry read per cycle, compare it in the next cycle
        scan_ctl.vld = rd_vld_q;
        if (iss_q != (IW+1)'(SLOTS)) begin
          rd_vld_d = 1'b1;
          iss_d    = iss_q + 1'b1;
        end
      end
      bbc_pkg::S_FIN: begin
        done_d = 1'b1;
        if (scan_flags.hit) begin
          res_slot_d = hit_idx_x[bbc_pkg::SLOT_W-1:0];
          res_hit_d  = 1'b1;
          waddr      = hit_idx;
          if (hit_rec.cnt == bbc_pkg::CNT_MAX) begin
            res_rd_d = 1'b0;
            res_st_d = bbc_pkg::ST_OVER;
          end else begin
            we       = 1'b1;
            wrec     = hit_rec;
            wrec.cnt = hit_rec.cnt + 1'b1;
            wrec.dv  = 1'b1;
            res_rd_d = !hit_rec.dv;
            res_st_d = bbc_pkg::ST_OK;
          end
        end else if (scan_flags.vic) begin
          // Retag the oldest free slot, keeping its stamp
          we         = 1'b1;
          waddr      = vic_idx;
          wrec.dev   = dev_q;
          wrec.blk   = blk_q;
          wrec.cnt   = bbc_pkg::CNT_W'(1);
          wrec.stamp = vic_stamp;
          wrec.dv    = 1'b1;
          res_slot_d = vic_idx_x[bbc_pkg::SLOT_W-1:0];
          res_hit_d  = 1'b0;
          res_rd_d   = 1'b1;
          res_st_d   = bbc_pkg::ST_OK;
        end else begin
          res_slot_d = '0;
          res_hit_d  = 1'b0;
          res_rd_d   = 1'b0;
          res_st_d   = bbc_pkg::ST_NOSLOT;
        end
      end
      bbc_pkg::S_OP: begin
        done_d     = 1'b1;
        res_slot_d = slot_in_q;
        res_hit_d  = 1'b0;
        res_rd_d   = 1'b0;
        res_st_d   = bbc_pkg::ST_OK;
        if (op_q == bbc_pkg::OP_PIN) begin
          if (rrec.cnt == bbc_pkg::CNT_MAX) begin
            res_st_d = bbc_pkg::ST_OVER;
          end else begin
            we       = 1'b1;
            wrec.cnt = rrec.cnt + 1'b1;
          end
        end else if (rrec.cnt == '0) begin
          res_st_d = bbc_pkg::ST_UNDER;
        end else begin
          // Release or unpin; only a final release stamps the time
          we       = 1'b1;
          wrec.cnt = cnt_dec;
          if ((op_q == bbc_pkg::OP_RELEASE) && (cnt_dec == '0)) begin
            wrec.stamp = now_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bbc_pkg::S_IDLE;
      iss_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= bbc_pkg::op_e'(opcode_i);
      dev_q     <= device_i;
      blk_q     <= block_number_i;
      slot_in_q <= slot_in_i;
      slot_q    <= slot_idx_in;
      now_q     <= now_i;
    end
    rd_idx_q   <= iss_q[IW-1:0];
    res_slot_q <= res_slot_d;
    res_hit_q  <= res_hit_d;
    res_rd_q   <= res_rd_d;
    res_st_q   <= res_st_d;
  end

  assign busy_o       = (state_q != bbc_pkg::S_IDLE);
  assign done_o       = done_q;
  assign slot_out_o   = res_slot_q;
  assign hit_o        = res_hit_q;
  assign needs_read_o = res_rd_q;
  assign status_o     = res_st_q;

endmodule

>>> tb/sv/block_buffer_cache_lru_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit_tb
// Self-checking bench for the buffer cache tag store. A generator queues
// get, release, pin and unpin requests. It starts with directed cases and
// continues with random sequences: tag reuse, slot fills past capacity,
// count saturation and release runs. A clocked driver issues the requests
// with random gaps. A behavioural model predicts every reply when its request is
// taken, and a clocked monitor compares each strobed reply field by field.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit_tb;
  import bbc_pkg::*;

  localparam int unsigned SLOTS     = SLOTS_DEF;
  localparam int unsigned ITEMS     = 1750;
  localparam int unsigned TAIL_CYC  = 50;
  localparam int unsigned MAX_GAP   = 45;

  typedef struct {
    op_e                op;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [SLOT_W-1:0]  slot;
    logic [STAMP_W-1:0] now;
    bit                 drain;  // hold off until all replies are in
  } cache_req_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              rd;
    st_e               status;
  } cache_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                start_r = 1'b0;
  logic [1:0]          opcode_r = OP_GET;
  logic [DEV_W-1:0]    device_r = '0;
  logic [BLK_W-1:0]    block_r = '0;
  logic [SLOT_W-1:0]   slot_r = '0;
  logic [STAMP_W-1:0]  now_r = '0;

  logic                busy_o;
  logic                done_o;
  logic [SLOT_W-1:0]   slot_out_o;
  logic                hit_o;
  logic                needs_read_o;
  logic [1:0]          status_o;

  block_buffer_cache_lru_unit #(.SLOTS(SLOTS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_r),
    .busy_o         (busy_o),
    .opcode_i       (opcode_r),
    .device_i       (device_r),
    .block_number_i (block_r),
    .slot_in_i      (slot_r),
    .now_i          (now_r),
    .done_o         (done_o),
    .slot_out_o     (slot_out_o),
    .hit_o          (hit_o),
    .needs_read_o   (needs_read_o),
    .status_o       (status_o)
  );

  // Clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model copy of the tag store
  logic [DEV_W-1:0]   cache_dev   [SLOTS];
  logic [BLK_W-1:0]   cache_blk   [SLOTS];
  logic [CNT_W-1:0]   cache_refs  [SLOTS];
  logic [STAMP_W-1:0] cache_stamp [SLOTS];
  logic               cache_valid [SLOTS];

  cache_req_t   request_q[$];
  cache_reply_t reply_q[$];

  cache_req_t  cur_req;
  bit          req_open = 1'b0;
  bit          drain_next = 1'b0;
  int unsigned gap_left = 0;
  int unsigned n_queued = 0;
  int unsigned n_issued = 0;
  int unsigned n_done = 0;
  int unsigned errors = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cache_dev[i]   = '0;
      cache_blk[i]   = '0;
      cache_refs[i]  = '0;
      cache_stamp[i] = '0;
      cache_valid[i] = 1'b0;
    end
  end

  // Apply one request to the model and return the reply it causes
  task automatic lookup_and_update(input cache_req_t rq, output cache_reply_t rs);
    int found;
    int victim;
    rs = '{slot: rq.slot, hit: 1'b0, rd: 1'b0, status: ST_OK};
    if (rq.op == OP_GET) begin
      found = -1;
      for (int i = 0; i < SLOTS; i++)
        if (found < 0 && cache_dev[i] == rq.dev && cache_blk[i] == rq.blk) found = i;
      if (found >= 0) begin
        rs.slot = SLOT_W'(found);
        rs.hit  = 1'b1;
        if (cache_refs[found] == CNT_MAX) begin
          rs.status = ST_OVER;
        end else begin
          cache_refs[found]  = cache_refs[found] + 1'b1;
          rs.rd              = !cache_valid[found];
          cache_valid[found] = 1'b1;
        end
      end else begin
        // oldest unreferenced slot, lowest index on ties
        victim = -1;
        for (int i = 0; i < SLOTS; i++)
          if (cache_refs[i] == '0 && (victim < 0 || cache_stamp[i] < cache_stamp[victim]))
            victim = i;
        if (victim < 0) begin
          rs.slot   = '0;
          rs.status = ST_NOSLOT;
        end else begin
          cache_dev[victim]   = rq.dev;
          cache_blk[victim]   = rq.blk;
          cache_refs[victim]  = CNT_W'(1);
          cache_valid[victim] = 1'b1;
          rs.slot             = SLOT_W'(victim);
          rs.rd               = 1'b1;
        end
      end
    end else if (rq.slot >= SLOTS) begin
      rs.status = ST_NOSLOT;
    end else if (rq.op == OP_PIN) begin
      if (cache_refs[rq.slot] == CNT_MAX) rs.status = ST_OVER;
      else cache_refs[rq.slot] = cache_refs[rq.slot] + 1'b1;
    end else begin
      // release or unpin; only a release stamps the tick
      if (cache_refs[rq.slot] == '0) begin
        rs.status = ST_UNDER;
      end else begin
        cache_refs[rq.slot] = cache_refs[rq.slot] - 1'b1;
        if (rq.op == OP_RELEASE && cache_refs[rq.slot] == '0) cache_stamp[rq.slot] = rq.now;
      end
    end
  endtask

  // Driver: issue queued requests, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    cache_reply_t rs;
    bit fire;
    bit launch;
    bit steady;
    if (!rst_ni) begin
      start_r <= 1'b0;
    end else begin
      fire   = start_r && !busy_o;
      launch = 1'b0;
      steady = (n_issued >= 300 && n_issued < 700);
      if (fire) begin
        lookup_and_update(cur_req, rs);
        reply_q.push_back(rs);
        n_issued++;
        req_open = 1'b0;
        if (!steady && $urandom_range(0, 99) < 37) gap_left = $urandom_range(1, MAX_GAP);
      end
      if (!req_open && request_q.size() != 0) begin
        cur_req  = request_q.pop_front();
        req_open = 1'b1;
      end
      if (fire || !start_r) begin
        if (gap_left != 0) gap_left--;
        else if (req_open && (!cur_req.drain || n_issued == n_done)) launch = 1'b1;
      end
      if (launch) begin
        opcode_r <= cur_req.op;
        device_r <= cur_req.dev;
        block_r  <= cur_req.blk;
        slot_r   <= cur_req.slot;
        now_r    <= cur_req.now;
      end
      start_r <= launch || (start_r && !fire);
    end
  end

  // Monitor: every strobed reply against the oldest prediction
  always @(posedge clk_i) begin : check_replies
    cache_reply_t want;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $display("%0t unexpected reply: expected none, actual slot %0d hit %0b rd %0b st %0d",
                 $time, slot_out_o, hit_o, needs_read_o, status_o);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (slot_out_o !== want.slot) begin
          $display("%0t slot_out: expected %0d, actual %0d", $time, want.slot, slot_out_o);
          errors++;
        end
        if (hit_o !== want.hit) begin
          $display("%0t hit: expected %0b, actual %0b", $time, want.hit, hit_o);
          errors++;
        end
        if (needs_read_o !== want.rd) begin
          $display("%0t needs_read: expected %0b, actual %0b", $time, want.rd, needs_read_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t status: expected %s, actual %0d", $time, want.status.name(), status_o);
          errors++;
        end
        n_done <= n_done + 1;
      end
    end
  end

  // Queue one request, keeping the queue short so the generator sees fresh state
  task automatic push_req(input op_e op, input logic [DEV_W-1:0] dev,
                          input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot,
                          input logic [STAMP_W-1:0] now);
    cache_req_t rq;
    while (request_q.size() >= 4) @(negedge clk_i);
    rq = '{op: op, dev: dev, blk: blk, slot: slot, now: now, drain: drain_next};
    drain_next = 1'b0;
    request_q.push_back(rq);
    n_queued++;
  endtask

  // Wait until the model has taken every queued request; next one drains first
  task automatic settle_requests();
    while (request_q.size() != 0 || req_open) @(negedge clk_i);
    drain_next = 1'b1;
  endtask

  // Stimulus
  initial begin : gen_requests
    logic [STAMP_W-1:0] tick;
    logic [DEV_W-1:0]   hdev;
    logic [BLK_W-1:0]   hblk;
    logic [SLOT_W-1:0]  s;
    int unsigned        kind;
    int unsigned        n;
    int unsigned        k;
    int                 hslot;

    tick = 32'd1000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset tags are all (0, 0): lowest slot hits, read needed
    push_req(OP_GET, 8'h00, 32'h0000_0000, 5'h1F, 32'hFFFF_FFFF);
    push_req(OP_GET, 8'h00, 32'h0000_0000, 5'h00, 32'h0000_0000);
    push_req(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'h0A, 32'h5555_5555);
    push_req(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
    push_req(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF);
    push_req(OP_RELEASE, 8'hA5, 32'hAAAA_AAAA, 5'd0, 32'd3);     // underflow
    push_req(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'd4);              // underflow
    push_req(OP_PIN, 8'h00, 32'h0, 5'd31, 32'd4);
    push_req(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'd9);              // to zero, no stamp
    push_req(OP_GET, 8'h00, 32'h0000_0000, 5'h15, 32'h0);        // hit, valid already
    push_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd100);
    push_req(OP_GET, 8'h01, 32'h8000_0000, 5'h00, 32'h0);        // tie among stamp 0
    push_req(OP_RELEASE, 8'h00, 32'h0, 5'd1, 32'd7);
    push_req(OP_RELEASE, 8'h00, 32'h0, 5'd2, 32'd7);
    push_req(OP_GET, 8'h02, 32'h0000_0005, 5'h00, 32'h0);
    push_req(OP_PIN, 8'h00, 32'h0, 5'd0, 32'h0);
    push_req(OP_PIN, 8'h00, 32'h0, 5'd0, 32'h0);
    push_req(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'h0);
    push_req(OP_GET, 8'h00, 32'h0000_0000, 5'h00, 32'h0);        // hit on pinned slot
    push_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd200);
    push_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd201);

    // get the same block until its count saturates, then release it all
    settle_requests();
    hdev = DEV_W'($urandom);
    hblk = $urandom;
    repeat (258) push_req(OP_GET, hdev, hblk, SLOT_W'($urandom), $urandom);
    settle_requests();
    hslot = 0;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (cache_dev[i] == hdev && cache_blk[i] == hblk) hslot = i;
    repeat (257) begin
      tick = tick + $urandom_range(0, 9);
      push_req(OP_RELEASE, DEV_W'($urandom), $urandom, SLOT_W'(hslot), tick);
    end

    // pin one slot past saturation, then unpin below zero
    settle_requests();
    s = SLOT_W'($urandom);
    repeat (260) push_req(OP_PIN, DEV_W'($urandom), $urandom, s, $urandom);
    settle_requests();
    k = 32'(cache_refs[s]) + 3;
    repeat (k) push_req(OP_UNPIN, DEV_W'($urandom), $urandom, s, $urandom);

    // random sequences
    while (n_queued < ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 30 || (kind >= 85 && kind < 97)) begin
        // gets: mostly tags already held, some from a small pool, some fresh
        n = $urandom_range(1, 8);
        repeat (n) begin
          k = $urandom_range(0, 99);
          if (k < 55) begin
            hslot = $urandom_range(0, SLOTS - 1);
            hdev  = cache_dev[hslot];
            hblk  = cache_blk[hslot];
          end else if (k < 80) begin
            hdev = DEV_W'($urandom_range(0, 3));
            hblk = {($urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'h0), 3'($urandom_range(0, 7))};
          end else begin
            hdev = DEV_W'($urandom);
            hblk = $urandom;
          end
          push_req(OP_GET, hdev, hblk, SLOT_W'($urandom), $urandom);
        end
      end else if (kind < 55) begin
        // releases aimed at referenced slots, rising ticks
        n = $urandom_range(1, 6);
        repeat (n) begin
          hslot = $urandom_range(0, SLOTS - 1);
          for (int j = 0; j < SLOTS; j++)
            if (cache_refs[(hslot + j) % SLOTS] != '0 && cache_refs[hslot] == '0)
              hslot = (hslot + j) % SLOTS;
          tick = tick + $urandom_range(0, 50);
          push_req(($urandom_range(0, 4) == 0) ? OP_UNPIN : OP_RELEASE, DEV_W'($urandom),
                   $urandom, SLOT_W'(hslot),
                   ($urandom_range(0, 9) == 0) ? 32'($urandom) : tick);
        end
      end else if (kind < 70) begin
        // pin then maybe unpin on random slots
        n = $urandom_range(1, 4);
        repeat (n) begin
          s = SLOT_W'($urandom);
          push_req(OP_PIN, DEV_W'($urandom), $urandom, s, $urandom);
          if ($urandom_range(0, 1)) push_req(OP_UNPIN, DEV_W'($urandom), $urandom, s, $urandom);
        end
      end else if (kind < 85) begin
        // noise
        n = $urandom_range(1, 4);
        repeat (n) push_req(op_e'($urandom_range(0, 3)), DEV_W'($urandom), $urandom,
                            SLOT_W'($urandom), $urandom);
      end else begin
        // fill every free slot and miss at least twice, then release each slot held four times or fewer
        settle_requests();
        repeat (SLOTS + 2) push_req(OP_GET, DEV_W'($urandom), $urandom, SLOT_W'($urandom),
                                    $urandom);
        settle_requests();
        for (int i = 0; i < SLOTS; i++) begin
          k = 32'(cache_refs[i]);
          if (k <= 4) begin
            repeat (k) begin
              tick = tick + $urandom_range(0, 20);
              push_req(OP_RELEASE, DEV_W'($urandom), $urandom, SLOT_W'(i), tick);
            end
          end
        end
      end
    end

    // let everything drain, then keep watching for stray replies
    while (request_q.size() != 0 || req_open || n_done != n_issued) @(negedge clk_i);
    repeat (TAIL_CYC) @(negedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("block_buffer_cache_lru_unit regression: pass");
    end else begin
      $display("block_buffer_cache_lru_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("block_buffer_cache_lru_unit regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/bbc_pkg.sv
rtl/bbc_store.sv
rtl/bbc_scan.sv
rtl/block_buffer_cache_lru_unit.sv
tb/sv/block_buffer_cache_lru_unit_tb.sv
